FILE: rtl/sync_length_packet_deframer_assert.svh
// ---------------------------------------------------------------------------
// sync_length_packet_deframer_assert.svh
// assertion macros used by the deframer parser rtl
// ---------------------------------------------------------------------------
`ifndef SYNC_LENGTH_PACKET_DEFRAMER_ASSERT_SVH
`define SYNC_LENGTH_PACKET_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SLD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sld_pkg.sv
// ---------------------------------------------------------------------------
// sld_pkg
// types and constants shared by the packet deframer modules
// ---------------------------------------------------------------------------
package sld_pkg;

  // result kinds
  localparam logic [1:0] KIND_NONE      = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
  localparam logic [1:0] KIND_TYPE_ONLY = 2'd2;
  localparam logic [1:0] KIND_REJECT    = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_SYNC  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_SYNC = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LENGTH  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH  = 8'd3;
  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic [7:0]  FIRST_SYNC_RESET  = 8'd170;
  localparam logic [7:0]  SECOND_SYNC_RESET = 8'd85;
  localparam logic [15:0] MIN_LENGTH_RESET  = 16'd1;
  localparam logic [15:0] MAX_LENGTH_RESET  = 16'd1025;

  localparam int unsigned OUT_TDATA_W = 136;

  typedef struct packed {
    logic [7:0]  first_sync_byte;
    logic [7:0]  second_sync_byte;
    logic [15:0] min_declared_length;
    logic [15:0] max_declared_length;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  packet_type;
    logic [7:0]  payload_byte;
    logic [15:0] payload_position;
    logic [15:0] payload_length;
    logic        last_of_packet;
    logic [15:0] rejected_length;
    logic [31:0] packet_start_offset;
    logic [31:0] packets_completed;
    logic        partial_packet;
  } result_t;

endpackage

FILE: rtl/sld_cfg_regs.sv
// ---------------------------------------------------------------------------
// sld_cfg_regs
// configuration register file, written through the cfg channel
// ---------------------------------------------------------------------------
module sld_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sld_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sld_pkg::CFG_DATA_W-1:0]  cfg_data,
  output sld_pkg::cfg_t                   cfg
);
  import sld_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_sync_byte     <= FIRST_SYNC_RESET;
      cfg.second_sync_byte    <= SECOND_SYNC_RESET;
      cfg.min_declared_length <= MIN_LENGTH_RESET;
      cfg.max_declared_length <= MAX_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FIRST_SYNC:  cfg.first_sync_byte     <= cfg_data[7:0];
        CFG_SECOND_SYNC: cfg.second_sync_byte    <= cfg_data[7:0];
        CFG_MIN_LENGTH:  cfg.min_declared_length <= cfg_data;
        CFG_MAX_LENGTH:  cfg.max_declared_length <= cfg_data;
        default: ; // unknown index, dropped
      endcase
    end
  end

endmodule

FILE: rtl/sld_parser.sv
// ---------------------------------------------------------------------------
// sld_parser
// frame parser: phase register, length and counters, one result per word
// ---------------------------------------------------------------------------
`include "sync_length_packet_deframer_assert.svh"

module sld_parser (
  input  logic             clk,
  input  logic             rst,
  input  sld_pkg::cfg_t    cfg,
  input  logic             accept,
  input  logic [7:0]       stream_byte,
  output sld_pkg::result_t res
);
  import sld_pkg::*;

  localparam logic [2:0] PH_SYNC0   = 3'd0;
  localparam logic [2:0] PH_SYNC1   = 3'd1;
  localparam logic [2:0] PH_LENLO   = 3'd2;
  localparam logic [2:0] PH_LENHI   = 3'd3;
  localparam logic [2:0] PH_TYPE    = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] payload_count, payload_count_next;
  logic [15:0] byte_pos, byte_pos_next;
  logic [7:0]  type_byte, type_byte_next;
  logic [31:0] stream_offset, stream_offset_next;
  logic [31:0] start_offset, start_offset_next;
  logic [31:0] delivered, delivered_next;
  logic [15:0] length_full;
  logic        length_bad;
  logic        pay_word;
  logic        end_word;

  assign length_full = {stream_byte, frame_length[7:0]};
  assign length_bad  = (length_full == 16'd0) ||
                       (length_full < cfg.min_declared_length) ||
                       (length_full > cfg.max_declared_length);

  always_comb begin
    phase_next           = phase;
    frame_length_next    = frame_length;
    payload_count_next   = payload_count;
    byte_pos_next        = byte_pos;
    type_byte_next       = type_byte;
    stream_offset_next   = stream_offset + 32'd1;
    start_offset_next    = start_offset;
    delivered_next       = delivered;
    res                  = '0;

    unique case (phase)
      PH_SYNC1: begin
        if (stream_byte == cfg.second_sync_byte) begin
          phase_next = PH_LENLO;
        end else if (stream_byte == cfg.first_sync_byte) begin
          // repeated first sync restarts the frame here
          start_offset_next = stream_offset;
        end else begin
          phase_next = PH_SYNC0;
        end
      end
      PH_LENLO: begin
        frame_length_next = {8'd0, stream_byte};
        phase_next        = PH_LENHI;
      end
      PH_LENHI: begin
        frame_length_next = length_full;
        if (length_bad) begin
          res.result_kind     = KIND_REJECT;
          res.rejected_length = length_full;
          phase_next          = PH_SYNC0;
        end else begin
          payload_count_next = length_full - 16'd1;
          byte_pos_next      = 16'd0;
          phase_next         = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_byte_next = stream_byte;
        if (payload_count == 16'd0) begin
          delivered_next     = delivered + 32'd1;
          res.result_kind    = KIND_TYPE_ONLY;
          res.packet_type    = stream_byte;
          res.last_of_packet = 1'b1;
          phase_next         = PH_SYNC0;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res.result_kind      = KIND_PAYLOAD;
        res.packet_type      = type_byte;
        res.payload_byte     = stream_byte;
        res.payload_position = byte_pos;
        res.payload_length   = payload_count;
        byte_pos_next        = byte_pos + 16'd1;
        if (byte_pos_next >= payload_count) begin
          delivered_next     = delivered + 32'd1;
          res.last_of_packet = 1'b1;
          phase_next         = PH_SYNC0;
        end
      end
      default: begin
        // hunting, unused codes included
        if (stream_byte == cfg.first_sync_byte) begin
          start_offset_next = stream_offset;
          phase_next        = PH_SYNC1;
        end else begin
          phase_next = PH_SYNC0;
        end
      end
    endcase

    res.packet_start_offset = start_offset_next;
    res.packets_completed   = delivered_next;
    res.partial_packet      = (phase_next != PH_SYNC0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC0;
      frame_length  <= '0;
      payload_count <= '0;
      byte_pos      <= '0;
      type_byte     <= '0;
      stream_offset <= '0;
      start_offset  <= '0;
      delivered     <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      frame_length  <= frame_length_next;
      payload_count <= payload_count_next;
      byte_pos      <= byte_pos_next;
      type_byte     <= type_byte_next;
      stream_offset <= stream_offset_next;
      start_offset  <= start_offset_next;
      delivered     <= delivered_next;
    end
  end

  assign pay_word = accept && (phase == PH_PAYLOAD);
  assign end_word = accept && res.last_of_packet;

  `SLD_ASSERT_NOW(a_payload_kind, pay_word, res.result_kind == KIND_PAYLOAD, "no payload result")
  `SLD_ASSERT_NEXT(a_last_hunt, end_word, phase == PH_SYNC0, "not hunting after packet end")
  `SLD_ASSERT_NEXT(a_count_step, end_word, delivered == $past(delivered) + 32'd1, "no count step")

endmodule

FILE: rtl/sld_out_skid.sv
// ---------------------------------------------------------------------------
// sld_out_skid
// result register with a skid stage, parts the parser from the output stall
// ---------------------------------------------------------------------------
module sld_out_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sld_pkg::result_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sld_pkg::result_t out_data
);
  import sld_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      // output stalled, park the word
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else begin
        out_data <= in_data;
      end
    end else if (in_valid && in_ready) begin
      skid_data <= in_data;
    end
  end

endmodule

FILE: rtl/sync_length_packet_deframer.sv
// ---------------------------------------------------------------------------
// sync_length_packet_deframer
// two-byte sync, length-prefixed packet deframer, one result per stream byte
//
//   channel   dir  handshake                         content
//   s_axis    in   s_axis_tvalid / s_axis_tready     one stream byte
//   m_axis    out  m_axis_tvalid / m_axis_tready     one result, tlast at packet end
//   cfg       in   cfg_valid / cfg_ready             register index and value
//
// one byte is accepted per cycle while the skid stage is empty; its result goes
// to the result register, through the skid stage when the output stalls. the parser
// state updates in the same cycle the byte is taken, so bytes follow back to back.
// a skid stage keeps input ready for one more byte while the output stalls.
// rst is synchronous; registers return to their defaults, parser hunts.
// ---------------------------------------------------------------------------
module sync_length_packet_deframer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // stream_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // packet_type, payload_byte, payload_position, payload_length, rejected_length,
  // packet_start_offset, packets_completed, partial_packet, zero fill
  output logic [sld_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,  // last_of_packet
  output logic [1:0]                      m_axis_tuser,  // result_kind
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sld_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sld_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sld_pkg::*;

  cfg_t    cfg;
  result_t parse_res;
  result_t out_res;
  logic    accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  sld_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sld_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .stream_byte (s_axis_tdata),
    .res         (parse_res)
  );

  sld_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_ready  (s_axis_tready),
    .in_data   (parse_res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = {7'd0,
                         out_res.partial_packet,
                         out_res.packets_completed,
                         out_res.packet_start_offset,
                         out_res.rejected_length,
                         out_res.payload_length,
                         out_res.payload_position,
                         out_res.payload_byte,
                         out_res.packet_type};
  assign m_axis_tlast = out_res.last_of_packet;
  assign m_axis_tuser = out_res.result_kind;

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the two-byte sync, length-prefixed packet deframer.
// a cycle-free model in the bench predicts the result word for every stream
// byte taken; a monitor compares each result word with the oldest prediction.
// directed frames come first, then randomised traffic under several register
// settings with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb;
  import sld_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;

  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, LEN_LOW, LEN_HIGH, TYPE_BYTE, PAYLOAD
  } phase_e;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic [1:0]             m_axis_tuser;
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data      = '0;

  sync_length_packet_deframer DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // deframer model state
  cfg_t        regs;
  phase_e      phase;
  logic [15:0] length_seen;
  logic [15:0] payload_total;
  logic [15:0] payload_next;
  logic [7:0]  current_type;
  logic [31:0] byte_offset;
  logic [31:0] frame_start;
  logic [31:0] delivered;

  result_t     pending_results[$];
  int unsigned failures    = 0;
  int unsigned bytes_sent  = 0;
  int          idle_cycles = 0;
  int          hold_left   = 0;
  bit          sender_gaps = 1'b1;
  bit          sink_stalls = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void reset_model();
    regs.first_sync_byte     = FIRST_SYNC_RESET;
    regs.second_sync_byte    = SECOND_SYNC_RESET;
    regs.min_declared_length = MIN_LENGTH_RESET;
    regs.max_declared_length = MAX_LENGTH_RESET;
    phase         = HUNT_FIRST;
    length_seen   = '0;
    payload_total = '0;
    payload_next  = '0;
    current_type  = '0;
    byte_offset   = '0;
    frame_start   = '0;
    delivered     = '0;
  endfunction

  // advances the deframer model by one stream byte, returns its result word
  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t     r;
    logic [31:0] here;
    r = '0;
    r.result_kind = KIND_NONE;
    here = byte_offset;
    byte_offset = byte_offset + 32'd1;
    case (phase)
      HUNT_SECOND: begin
        if (b == regs.second_sync_byte) phase = LEN_LOW;
        else if (b == regs.first_sync_byte) frame_start = here;
        else phase = HUNT_FIRST;
      end
      LEN_LOW: begin
        length_seen = {8'd0, b};
        phase = LEN_HIGH;
      end
      LEN_HIGH: begin
        length_seen = {b, length_seen[7:0]};
        if (length_seen == 16'd0 || length_seen < regs.min_declared_length ||
            length_seen > regs.max_declared_length) begin
          r.result_kind     = KIND_REJECT;
          r.rejected_length = length_seen;
          phase = HUNT_FIRST;
        end else begin
          payload_total = length_seen - 16'd1;
          payload_next  = '0;
          phase = TYPE_BYTE;
        end
      end
      TYPE_BYTE: begin
        current_type = b;
        if (payload_total == 16'd0) begin
          delivered = delivered + 32'd1;
          r.result_kind    = KIND_TYPE_ONLY;
          r.packet_type    = current_type;
          r.last_of_packet = 1'b1;
          phase = HUNT_FIRST;
        end else begin
          phase = PAYLOAD;
        end
      end
      PAYLOAD: begin
        r.result_kind      = KIND_PAYLOAD;
        r.packet_type      = current_type;
        r.payload_byte     = b;
        r.payload_position = payload_next;
        r.payload_length   = payload_total;
        payload_next = payload_next + 16'd1;
        if (payload_next >= payload_total) begin
          delivered = delivered + 32'd1;
          r.last_of_packet = 1'b1;
          phase = HUNT_FIRST;
        end
      end
      default: begin
        if (b == regs.first_sync_byte) begin
          frame_start = here;
          phase = HUNT_SECOND;
        end else begin
          phase = HUNT_FIRST;
        end
      end
    endcase
    r.packet_start_offset = frame_start;
    r.packets_completed   = delivered;
    r.partial_packet      = (phase != HUNT_FIRST);
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(deframe_byte(b));
    bytes_sent++;
    @(negedge clk);
  endtask

  // input stops and every expected word must have arrived
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FIRST_SYNC:  regs.first_sync_byte     = value[7:0];
      CFG_SECOND_SYNC: regs.second_sync_byte    = value[7:0];
      CFG_MIN_LENGTH:  regs.min_declared_length = value;
      CFG_MAX_LENGTH:  regs.max_declared_length = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] first, input logic [7:0] second,
                            input logic [15:0] min_len, input logic [15:0] max_len);
    write_register(CFG_FIRST_SYNC, {8'd0, first});
    write_register(CFG_SECOND_SYNC, {8'd0, second});
    write_register(CFG_MIN_LENGTH, min_len);
    write_register(CFG_MAX_LENGTH, max_len);
  endtask

  // a length the current bounds accept, or one they reject
  function automatic logic [15:0] pick_length(input bit in_range);
    int lo, hi;
    lo = (regs.min_declared_length == 16'd0) ? 1 : int'(regs.min_declared_length);
    hi = int'(regs.max_declared_length);
    if (lo > hi) return 16'($urandom_range(0, 65535));
    if (in_range) return 16'($urandom_range(lo, (hi < lo + 7) ? hi : lo + 7));
    case ($urandom_range(0, 2))
      0: return 16'd0;
      1: if (lo > 1) return 16'(lo - 1);
      default: if (hi < 65535) return 16'($urandom_range(hi + 1, 65535));
    endcase
    return 16'd0;
  endfunction

  task automatic send_header(input logic [15:0] len);
    push_byte(regs.first_sync_byte);
    push_byte(regs.second_sync_byte);
    push_byte(len[7:0]);
    push_byte(len[15:8]);
  endtask

  // full frame; body only when the length passes the bounds
  task automatic send_frame(input logic [15:0] len);
    send_header(len);
    if (len != 16'd0 && len >= regs.min_declared_length &&
        len <= regs.max_declared_length) begin
      push_byte(8'($urandom));
      repeat (int'(len) - 1) push_byte(8'($urandom));
    end
  endtask

  task automatic random_traffic(input int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          if ($urandom_range(0, 19) == 0 && regs.max_declared_length <= 16'd64)
            send_frame(regs.max_declared_length);
          else
            send_frame(pick_length(1'b1));
        end
        7: send_header(pick_length(1'b0));
        8: begin
          repeat ($urandom_range(1, 4))
            push_byte(($urandom_range(0, 3) == 0) ? regs.first_sync_byte : 8'($urandom));
        end
        default: begin
          case ($urandom_range(0, 2))
            0: begin
              push_byte(regs.first_sync_byte);
              repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
            end
            1: begin
              repeat ($urandom_range(1, 3)) push_byte(regs.first_sync_byte);
              send_frame(pick_length(1'b1));
            end
            default: begin
              // cut short, so the next frame lands in this one's payload
              send_header(pick_length(1'b1));
              repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
            end
          endcase
        end
      endcase
    end
  endtask

  task automatic test_default_frames();
    // type-only frame with the smallest length
    send_frame(16'd1);
    // three-byte frame with extreme byte values
    send_header(16'd3);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hFF);
    // repeated first sync restarts the frame
    push_byte(FIRST_SYNC_RESET);
    send_frame(16'd2);
    // zero length and one above the maximum are both rejected
    send_header(16'd0);
    send_header(MAX_LENGTH_RESET + 16'd1);
    // first sync followed by a stray byte
    push_byte(FIRST_SYNC_RESET);
    push_byte(8'h12);
  endtask

  // frame at the maximum length, then one just above it
  task automatic test_longest_frame();
    set_config(FIRST_SYNC_RESET, SECOND_SYNC_RESET, MIN_LENGTH_RESET, 16'd40);
    send_frame(16'd40);
    send_header(16'd41);
  endtask

  task automatic test_register_extremes();
    set_config(8'h00, 8'hFF, 16'd0, 16'hFFFF);
    send_frame(16'd0);
    send_frame(16'd1);
    send_frame(16'd2);
    // minimum above maximum rejects every length
    set_config(8'hFF, 8'h00, 16'd10, 16'd5);
    send_header(16'd7);
    send_header(16'd10);
    send_header(16'd5);
    // only the low byte of a sync register is kept, unknown indexes do nothing
    write_register(CFG_FIRST_SYNC, 16'hA53C);
    write_register(CFG_SECOND_SYNC, 16'h5AC3);
    write_register(CFG_MIN_LENGTH, 16'd1);
    write_register(CFG_MAX_LENGTH, 16'd1);
    write_register(CFG_INDEX_W'($urandom_range(4, 255)), 16'($urandom));
    write_register({CFG_INDEX_W{1'b1}}, 16'($urandom));
    send_frame(16'd1);
    send_header(16'd2);
  endtask

  task automatic test_backpressure();
    wait_idle();
    sender_gaps = 1'b0;
    hold_left = HOLD_CYCLES;
    repeat (4) send_frame(pick_length(1'b1));
    // sender now pauses until every word has drained
    wait_idle();
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    set_config(FIRST_SYNC_RESET, SECOND_SYNC_RESET, MIN_LENGTH_RESET, 16'd12);
    random_traffic(150);
    // a stretch with no idling on either side
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    set_config(8'($urandom), 8'($urandom), 16'($urandom_range(1, 4)), 16'($urandom_range(5, 14)));
    random_traffic(100);
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    // equal sync bytes
    set_config(8'h7E, 8'h7E, 16'd2, 16'd9);
    random_traffic(80);
    set_config(8'($urandom), 8'($urandom), 16'd0, 16'hFFFF);
    random_traffic(80);
    set_config(8'($urandom), 8'($urandom), 16'd4, 16'd4);
    random_traffic(40);
  endtask

  initial begin
    reset_model();
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_default_frames();
    test_longest_frame();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result sink with random stalls and an occasional long hold-off
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (sink_stalls) stall = pick_gap();
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    result_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.result_kind         = m_axis_tuser;
      got.packet_type         = m_axis_tdata[7:0];
      got.payload_byte        = m_axis_tdata[15:8];
      got.payload_position    = m_axis_tdata[31:16];
      got.payload_length      = m_axis_tdata[47:32];
      got.rejected_length     = m_axis_tdata[63:48];
      got.packet_start_offset = m_axis_tdata[95:64];
      got.packets_completed   = m_axis_tdata[127:96];
      got.partial_packet      = m_axis_tdata[128];
      got.last_of_packet      = m_axis_tlast;
      if (pending_results.size() == 0) begin
        $error("result word with no stream byte waiting for it");
        failures++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
        check_field("packet_type", 32'(want.packet_type), 32'(got.packet_type));
        check_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
        check_field("payload_position", 32'(want.payload_position),
                    32'(got.payload_position));
        check_field("payload_length", 32'(want.payload_length),
                    32'(got.payload_length));
        check_field("last_of_packet", 32'(want.last_of_packet),
                    32'(got.last_of_packet));
        check_field("rejected_length", 32'(want.rejected_length),
                    32'(got.rejected_length));
        check_field("packet_start_offset", want.packet_start_offset,
                    got.packet_start_offset);
        check_field("packets_completed", want.packets_completed, got.packets_completed);
        check_field("partial_packet", 32'(want.partial_packet),
                    32'(got.partial_packet));
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
